>>> rtl/core/biquad_pkg.sv
package biquad_pkg;

    // Filter geometry
    localparam int SECTIONS      = 3;
    localparam int COEFS_PER_SEC = 6;
    localparam int WORDS_PER_SEC = 2;
    localparam int COEF_DEPTH    = SECTIONS * COEFS_PER_SEC;
    localparam int ST_DEPTH      = SECTIONS * WORDS_PER_SEC;
    localparam int CADDR_W       = $clog2(COEF_DEPTH);
    localparam int SADDR_W       = $clog2(ST_DEPTH);
    localparam int SEC_W         = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int SECN_W        = $clog2(SECTIONS + 1) + 1;

    // Number format and divider
    localparam int QFRAC     = 27;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Item function codes
    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    // Coefficient slots within a section
    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A0 = 3'd3;
    localparam logic [2:0] SLOT_A1 = 3'd4;
    localparam logic [2:0] SLOT_A2 = 3'd5;

    typedef struct packed {
        logic               func;
        logic signed [31:0] sample_in;
        logic [3:0]         coef_section;
        logic [2:0]         coef_slot;
        logic signed [31:0] coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sample_out;
        logic               overflow;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_B0,
        ST_MUL_B0,
        ST_ADD_NUM,
        ST_DIV_PREP,
        ST_DIV,
        ST_DIV_END,
        ST_RD_B1,
        ST_MUL_B1,
        ST_MUL_A1,
        ST_MUL_B2,
        ST_MUL_A2,
        ST_FIN_T1,
        ST_WR_S1,
        ST_DONE
    } seq_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_X,
        DP_MUL_B0,
        DP_ADD_NUM,
        DP_DIV_PREP,
        DP_DIV_STEP,
        DP_DIV_END,
        DP_MUL_B1,
        DP_MUL_A1,
        DP_MUL_B2,
        DP_MUL_A2,
        DP_FIN_T1,
        DP_WR_S1
    } dp_op_t;

    typedef struct packed {
        logic [CADDR_W-1:0] coef_raddr;
        logic [SADDR_W-1:0] st_raddr;
        logic               st_we;
        logic [SADDR_W-1:0] st_waddr;
    } mem_req_t;

    typedef struct packed {
        logic               we;
        logic [CADDR_W-1:0] addr;
        logic signed [31:0] data;
    } coef_wr_t;

    // Coefficient table entry of one section and slot
    function automatic logic [CADDR_W-1:0] coef_addr(input logic [SEC_W-1:0] sec,
                                                     input logic [2:0] slot);
        return CADDR_W'(sec) * CADDR_W'(COEFS_PER_SEC) + CADDR_W'(slot);
    endfunction

    // State word of one section: word 0 is s0, word 1 is s1
    function automatic logic [SADDR_W-1:0] st_addr(input logic [SEC_W-1:0] sec,
                                                   input logic word);
        return SADDR_W'({sec, word});
    endfunction

    // True when a wide value does not fit a signed 32-bit word
    function automatic logic sat_hit(input logic signed [63:0] v);
        return !((&v[63:31]) || !(|v[63:31]));
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (sat_hit(v))
        begin
            return v[63] ? Q_MIN : Q_MAX;
        end
        return v[31:0];
    endfunction

endpackage

>>> rtl/core/biquad_ram.sv
module biquad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 18
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/biquad_store.sv
module biquad_store import biquad_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  coef_wr_t           coef_wr,
    input  mem_req_t           req,
    input  logic signed [31:0] st_wdata,
    output logic signed [31:0] coef_rd,
    output logic signed [31:0] st_rd
);

    logic [31:0]           coef_raw;
    logic [31:0]           st_raw;
    logic [COEF_DEPTH-1:0] coef_vld_reg;
    logic [ST_DEPTH-1:0]   st_vld_reg;
    logic                  coef_ok_reg;
    logic                  st_ok_reg;

    biquad_ram #(
        .WIDTH(32),
        .DEPTH(COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_wr.we),
        .waddr (coef_wr.addr),
        .wdata (coef_wr.data),
        .raddr (req.coef_raddr),
        .rdata (coef_raw)
    );

    biquad_ram #(
        .WIDTH(32),
        .DEPTH(ST_DEPTH)
    ) u_st_ram (
        .clk   (clk),
        .we    (req.st_we),
        .waddr (req.st_waddr),
        .wdata (st_wdata),
        .raddr (req.st_raddr),
        .rdata (st_raw)
    );

    // Track written entries; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            st_vld_reg   <= '0;
            coef_ok_reg  <= 1'b0;
            st_ok_reg    <= 1'b0;
        end
        else
        begin
            if (coef_wr.we)
            begin
                coef_vld_reg[coef_wr.addr] <= 1'b1;
            end
            if (req.st_we)
            begin
                st_vld_reg[req.st_waddr] <= 1'b1;
            end
            coef_ok_reg <= coef_vld_reg[req.coef_raddr];
            st_ok_reg   <= st_vld_reg[req.st_raddr];
        end
    end

    // Mask read data of unwritten entries
    assign coef_rd = coef_ok_reg ? $signed(coef_raw) : '0;
    assign st_rd   = st_ok_reg ? $signed(st_raw) : '0;

endmodule

>>> rtl/core/biquad_dp.sv
module biquad_dp import biquad_pkg::*; (
    input  logic               clk,
    input  dp_op_t             op,
    input  logic signed [31:0] sample,
    input  logic signed [31:0] cd,
    input  logic signed [31:0] md,
    output logic               div_bypass,
    output logic signed [31:0] st_wdata,
    output out_item_t          res
);

    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] a0_reg, a0_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        quo_reg, quo_next;
    logic [31:0]        dvs_reg, dvs_next;
    logic               qneg_reg, qneg_next;
    logic               flag_reg, flag_next;

    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [63:0] prod_sh;
    logic [63:0]        num_abs;
    logic [31:0]        a0_abs;
    logic               a0_zero;
    logic               quo_big;
    logic [32:0]        rem_sh;
    logic               rem_ge;

    // Shared multiplier: coefficient times input or output of the section
    assign mul_b   = (op == DP_MUL_A1 || op == DP_MUL_A2) ? y_reg : x_reg;
    assign mul_p   = cd * mul_b;
    assign prod_sh = prod_reg >>> QFRAC;

    // Divider setup: magnitudes and early saturation test
    assign num_abs    = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
    assign a0_abs     = a0_reg[31] ? (~a0_reg + 32'd1) : a0_reg;
    assign a0_zero    = (a0_reg == '0);
    assign quo_big    = (num_abs[63:32] >= a0_abs);
    assign div_bypass = a0_zero || quo_big;

    // One restoring step
    assign rem_sh = {rem_reg, quo_reg[31]};
    assign rem_ge = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        a0_next   = a0_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        qneg_next = qneg_reg;
        flag_next = flag_reg;
        unique case (op)
            DP_NOP:
            begin
            end
            DP_LOAD_X:
            begin
                x_next    = sample;
                flag_next = 1'b0;
            end
            DP_MUL_B0:
            begin
                prod_next = mul_p;
                acc_next  = 64'(md) <<< QFRAC;
            end
            DP_ADD_NUM:
            begin
                acc_next = acc_reg + prod_reg;
                a0_next  = cd;
            end
            DP_DIV_PREP:
            begin
                rem_next  = num_abs[63:32];
                quo_next  = num_abs[31:0];
                dvs_next  = a0_abs;
                qneg_next = acc_reg[63] ^ a0_reg[31];
                if (a0_zero)
                begin
                    flag_next = 1'b1;
                    if (acc_reg == '0)
                    begin
                        y_next = '0;
                    end
                    else
                    begin
                        y_next = acc_reg[63] ? Q_MIN : Q_MAX;
                    end
                end
                else if (quo_big)
                begin
                    flag_next = 1'b1;
                    y_next    = (acc_reg[63] ^ a0_reg[31]) ? Q_MIN : Q_MAX;
                end
            end
            DP_DIV_STEP:
            begin
                rem_next = rem_ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
                quo_next = {quo_reg[30:0], rem_ge};
            end
            DP_DIV_END:
            begin
                if (qneg_reg)
                begin
                    if (quo_reg > 32'h8000_0000)
                    begin
                        flag_next = 1'b1;
                        y_next    = Q_MIN;
                    end
                    else
                    begin
                        y_next = $signed(~quo_reg + 32'd1);
                    end
                end
                else
                begin
                    if (quo_reg[31])
                    begin
                        flag_next = 1'b1;
                        y_next    = Q_MAX;
                    end
                    else
                    begin
                        y_next = $signed(quo_reg);
                    end
                end
            end
            DP_MUL_B1:
            begin
                prod_next = mul_p;
                acc_next  = 64'(md);
            end
            DP_MUL_A1:
            begin
                acc_next  = acc_reg + prod_sh;
                prod_next = mul_p;
            end
            DP_MUL_B2:
            begin
                acc_next  = acc_reg - prod_sh;
                prod_next = mul_p;
            end
            DP_MUL_A2:
            begin
                flag_next = flag_reg | sat_hit(acc_reg);
                acc_next  = prod_sh;
                prod_next = mul_p;
            end
            DP_FIN_T1:
            begin
                acc_next = acc_reg - prod_sh;
            end
            DP_WR_S1:
            begin
                flag_next = flag_reg | sat_hit(acc_reg);
                x_next    = y_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        a0_reg   <= a0_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        flag_reg <= flag_next;
    end

    assign st_wdata       = sat32(acc_reg);
    assign res.sample_out = y_reg;
    assign res.overflow   = flag_reg;

endmodule

>>> rtl/core/biquad_seq.sv
module biquad_seq import biquad_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     div_bypass,
    input  logic     out_busy,
    output logic     idle,
    output dp_op_t   op,
    output mem_req_t mem_req,
    output logic     out_load
);

    seq_state_t       state_reg, state_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_sec;

    assign last_sec = (sec_reg == SEC_W'(SECTIONS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     state_next = start ? ST_RD_B0 : ST_IDLE;
            ST_RD_B0:    state_next = ST_MUL_B0;
            ST_MUL_B0:   state_next = ST_ADD_NUM;
            ST_ADD_NUM:  state_next = ST_DIV_PREP;
            ST_DIV_PREP: state_next = div_bypass ? ST_RD_B1 : ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:  state_next = ST_RD_B1;
            ST_RD_B1:    state_next = ST_MUL_B1;
            ST_MUL_B1:   state_next = ST_MUL_A1;
            ST_MUL_A1:   state_next = ST_MUL_B2;
            ST_MUL_B2:   state_next = ST_MUL_A2;
            ST_MUL_A2:   state_next = ST_FIN_T1;
            ST_FIN_T1:   state_next = ST_WR_S1;
            ST_WR_S1:    state_next = last_sec ? ST_DONE : ST_RD_B0;
            ST_DONE:     state_next = out_busy ? ST_DONE : ST_IDLE;
        endcase
    end

    // Section and divider step counters
    always_comb
    begin
        sec_next = sec_reg;
        cnt_next = cnt_reg;
        if (state_reg == ST_IDLE && start)
        begin
            sec_next = '0;
        end
        else if (state_reg == ST_WR_S1 && !last_sec)
        begin
            sec_next = sec_reg + SEC_W'(1);
        end
        if (state_reg == ST_DIV_PREP)
        begin
            cnt_next = '0;
        end
        else if (state_reg == ST_DIV)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sec_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Outputs: datapath step, memory addresses, result hand-off
    always_comb
    begin
        idle               = (state_reg == ST_IDLE);
        op                 = DP_NOP;
        out_load           = 1'b0;
        mem_req.coef_raddr = coef_addr(sec_reg, SLOT_B0);
        mem_req.st_raddr   = st_addr(sec_reg, 1'b0);
        mem_req.st_we      = 1'b0;
        mem_req.st_waddr   = st_addr(sec_reg, 1'b0);
        unique case (state_reg)
            ST_IDLE:
            begin
                op = start ? DP_LOAD_X : DP_NOP;
            end
            ST_RD_B0:
            begin
                mem_req.coef_raddr = coef_addr(sec_reg, SLOT_B0);
                mem_req.st_raddr   = st_addr(sec_reg, 1'b0);
            end
            ST_MUL_B0:
            begin
                op                 = DP_MUL_B0;
                mem_req.coef_raddr = coef_addr(sec_reg, SLOT_A0);
            end
            ST_ADD_NUM:
            begin
                op = DP_ADD_NUM;
            end
            ST_DIV_PREP:
            begin
                op = DP_DIV_PREP;
            end
            ST_DIV:
            begin
                op = DP_DIV_STEP;
            end
            ST_DIV_END:
            begin
                op = DP_DIV_END;
            end
            ST_RD_B1:
            begin
                mem_req.coef_raddr = coef_addr(sec_reg, SLOT_B1);
                mem_req.st_raddr   = st_addr(sec_reg, 1'b1);
            end
            ST_MUL_B1:
            begin
                op                 = DP_MUL_B1;
                mem_req.coef_raddr = coef_addr(sec_reg, SLOT_A1);
            end
            ST_MUL_A1:
            begin
                op                 = DP_MUL_A1;
                mem_req.coef_raddr = coef_addr(sec_reg, SLOT_B2);
            end
            ST_MUL_B2:
            begin
                op                 = DP_MUL_B2;
                mem_req.coef_raddr = coef_addr(sec_reg, SLOT_A2);
            end
            ST_MUL_A2:
            begin
                op               = DP_MUL_A2;
                mem_req.st_we    = 1'b1;
                mem_req.st_waddr = st_addr(sec_reg, 1'b0);
            end
            ST_FIN_T1:
            begin
                op = DP_FIN_T1;
            end
            ST_WR_S1:
            begin
                op               = DP_WR_S1;
                mem_req.st_we    = 1'b1;
                mem_req.st_waddr = st_addr(sec_reg, 1'b1);
            end
            ST_DONE:
            begin
                out_load = !out_busy;
            end
        endcase
    end

endmodule

>>> rtl/core/biquad_cascade_iir_filter.sv
// Channel  | Handshake                  | Payload    | Moves
// item     | item_valid / item_ready    | in_item_t  | sample to filter or coefficient
// result   | result_valid / result_ready| out_item_t | filtered sample and overflow flag
//
// A coefficient load leaves item_ready high. A sample runs through every section in turn,
// using the 32-step restoring divider and the shared 32x32 multiplier; a section whose a0
// is zero or whose quotient magnitude reaches 2^32 skips the divider. After reset all table
// entries read as zero (valid bits).
// The result waits in an output register while the next transaction is taken; a later
// result holds in the last sequencer step until that register is free.
module biquad_cascade_iir_filter import biquad_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic               item_accept;
    logic               start;
    logic               div_bypass;
    logic               out_busy;
    logic               out_load;
    dp_op_t             op;
    mem_req_t           mem_req;
    coef_wr_t           coef_wr;
    logic signed [31:0] coef_rd;
    logic signed [31:0] st_rd;
    logic signed [31:0] st_wdata;
    out_item_t          dp_res;
    logic               result_valid_reg;
    out_item_t          result_reg;

    assign item_accept = item_valid && item_ready;
    assign start       = item_accept && (item.func == FUNC_FILTER);

    // Coefficient load; drop out-of-range section or slot
    assign coef_wr.we   = item_accept && (item.func == FUNC_LOAD)
                          && ({1'b0, item.coef_section} < SECN_W'(SECTIONS))
                          && (item.coef_slot <= SLOT_A2);
    assign coef_wr.addr = coef_addr(SEC_W'(item.coef_section), item.coef_slot);
    assign coef_wr.data = item.coef_value;

    biquad_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .div_bypass (div_bypass),
        .out_busy   (out_busy),
        .idle       (item_ready),
        .op         (op),
        .mem_req    (mem_req),
        .out_load   (out_load)
    );

    biquad_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef_wr  (coef_wr),
        .req      (mem_req),
        .st_wdata (st_wdata),
        .coef_rd  (coef_rd),
        .st_rd    (st_rd)
    );

    biquad_dp u_dp (
        .clk        (clk),
        .op         (op),
        .sample     (item.sample_in),
        .cd         (coef_rd),
        .md         (st_rd),
        .div_bypass (div_bypass),
        .st_wdata   (st_wdata),
        .res        (dp_res)
    );

    // Output register: hold until the transaction completes
    assign out_busy = result_valid_reg && !result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= dp_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/core/biquad_chk.sv
module biquad_chk import biquad_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_ready,
    input in_item_t  item,
    input logic      result_valid,
    input logic      result_ready,
    input out_item_t result
);

    // A coefficient load leaves the block ready
    load_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.func == FUNC_LOAD) |=> item_ready)
        else $error("block not ready after coefficient load");

    // A sample keeps the block busy
    filter_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.func == FUNC_FILTER) |=> !item_ready)
        else $error("block still ready after taking a sample");

    // Finishing a sample always leaves a result in the output register
    ready_brings_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_ready) |-> result_valid)
        else $error("block went idle without a result");

    // A new result appears only as the block finishes a sample
    result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $rose(item_ready))
        else $error("result appeared while the block was not finishing");

    // A stalled result holds
    result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("stalled result dropped or changed");

endmodule

bind biquad_cascade_iir_filter biquad_chk u_chk (.*);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import biquad_pkg::*;

    localparam int ITEM_TARGET   = 650;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int ONE_Q         = 1 << QFRAC;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_MOSTLY,
        READY_LONG_STALL
    } ready_mode_t;

    typedef enum int {
        STYLE_TAME,
        STYLE_EDGY,
        STYLE_WILD
    } coef_style_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item_payload = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result_payload;

    // Predictor image of the block's coefficient table and section state
    logic signed [31:0] coef_img [COEF_DEPTH];
    logic signed [31:0] state_img [ST_DEPTH];
    out_item_t          expected_outputs [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int counted_items = 0;
    int filters_sent = 0;
    int loads_sent = 0;
    int ignored_loads = 0;
    int results_seen = 0;
    int overflow_seen = 0;
    int burst_left = 1;
    int ready_phase_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;

    biquad_cascade_iir_filter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_payload),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_payload)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_outputs.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Saturate a wide value to Q4.27; bit 32 flags a clip
    function automatic logic [32:0] clamp_q427(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return {1'b1, Q_MAX};
        end
        if (v < -64'sd2147483648)
        begin
            return {1'b1, Q_MIN};
        end
        return {1'b0, v[31:0]};
    endfunction

    // Advance the predictor by one transaction; queue the filtered sample
    task automatic biquad_predict(input in_item_t it);
        logic signed [63:0] xw, yw, num, b0, b1, b2, a0, a1, a2, m0, m1;
        logic signed [31:0] x;
        logic [32:0]        c;
        logic               ovf;
        int                 base;
        out_item_t          want;
        if (it.func == FUNC_LOAD)
        begin
            if (it.coef_section < SECTIONS && it.coef_slot < COEFS_PER_SEC)
            begin
                coef_img[it.coef_section * COEFS_PER_SEC + it.coef_slot] = it.coef_value;
            end
            return;
        end
        x   = it.sample_in;
        ovf = 1'b0;
        for (int s = 0; s < SECTIONS; s++)
        begin
            base = s * COEFS_PER_SEC;
            b0 = coef_img[base + SLOT_B0];
            b1 = coef_img[base + SLOT_B1];
            b2 = coef_img[base + SLOT_B2];
            a0 = coef_img[base + SLOT_A0];
            a1 = coef_img[base + SLOT_A1];
            a2 = coef_img[base + SLOT_A2];
            m0 = state_img[2 * s];
            m1 = state_img[2 * s + 1];
            xw = x;
            num = xw * b0 + (m0 <<< QFRAC);
            // Zero a0 pins the output to the sign of the numerator
            if (a0 == 0)
            begin
                ovf = 1'b1;
                if (num > 0)
                    yw = 64'sd2147483647;
                else if (num < 0)
                    yw = -64'sd2147483648;
                else
                    yw = 0;
            end
            else
            begin
                c   = clamp_q427(num / a0);
                ovf = ovf | c[32];
                yw  = $signed(c[31:0]);
            end
            // Products floor to Q4.27 before the exact sum
            c = clamp_q427(((b1 * xw) >>> QFRAC) - ((a1 * yw) >>> QFRAC) + m1);
            ovf = ovf | c[32];
            state_img[2 * s] = c[31:0];
            c = clamp_q427(((b2 * xw) >>> QFRAC) - ((a2 * yw) >>> QFRAC));
            ovf = ovf | c[32];
            state_img[2 * s + 1] = c[31:0];
            x = yw[31:0];
        end
        want.sample_out = x;
        want.overflow   = ovf;
        expected_outputs.push_back(want);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s on result %0d: got %h, expected %h",
                 $time, field, results_seen, got, want);
        mismatch_count++;
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                report_mismatch("unexpected result", result_payload.sample_out, 32'h0);
            end
            else
            begin
                want = expected_outputs.pop_front();
                results_seen++;
                if (want.overflow)
                    overflow_seen++;
                if (result_payload.sample_out !== want.sample_out)
                    report_mismatch("sample_out", result_payload.sample_out, want.sample_out);
                if (result_payload.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(result_payload.overflow),
                                    32'(want.overflow));
            end
        end
    end

    // Receiver back-pressure: switch between stall patterns, each held for a phase of random length
    always @(negedge clk)
    begin
        if (ready_phase_left == 0)
        begin
            ready_mode       = ready_mode_t'($urandom_range(0, 3));
            ready_phase_left = $urandom_range(50, 600);
        end
        else
        begin
            ready_phase_left--;
        end
        case (ready_mode)
            READY_ALWAYS:     result_ready <= 1'b1;
            READY_COIN:       result_ready <= 1'($urandom_range(0, 1));
            READY_MOSTLY:     result_ready <= ($urandom_range(0, 7) != 0);
            default:          result_ready <= ((ready_phase_left % 64) >= 40);
        endcase
    end

    // Present one transaction, hold it until taken, then pace the next burst
    task automatic send_item(input in_item_t it);
        @(negedge clk);
        item_valid   = 1'b1;
        item_payload = it;
        do
            @(posedge clk);
        while (!item_ready);
        biquad_predict(it);
        if (it.func == FUNC_FILTER)
        begin
            filters_sent++;
            counted_items++;
        end
        else if (it.coef_section < SECTIONS && it.coef_slot < COEFS_PER_SEC)
        begin
            loads_sent++;
            counted_items++;
        end
        else
        begin
            ignored_loads++;
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            @(negedge clk);
            item_valid = 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(20, 60)) @(negedge clk);
            else
                repeat ($urandom_range(0, 12)) @(negedge clk);
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 8);
        end
    endtask

    function automatic in_item_t load_item(input logic [3:0] sec, input logic [2:0] slot,
                                           input logic signed [31:0] value);
        in_item_t it;
        it.func         = FUNC_LOAD;
        it.sample_in    = $urandom;
        it.coef_section = sec;
        it.coef_slot    = slot;
        it.coef_value   = value;
        return it;
    endfunction

    function automatic in_item_t sample_item(input logic signed [31:0] x);
        in_item_t it;
        it.func         = FUNC_FILTER;
        it.sample_in    = x;
        it.coef_section = 4'($urandom_range(0, 15));
        it.coef_slot    = 3'($urandom_range(0, 7));
        it.coef_value   = $urandom;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_span(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return $signed($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return rand_span(2 * ONE_Q);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coef(input logic [2:0] slot,
                                                     input coef_style_t style);
        logic signed [31:0] v;
        if (style == STYLE_WILD)
            return $signed($urandom);
        case (slot)
            SLOT_A0:
            begin
                v = int'($urandom_range(ONE_Q / 2, 2 * ONE_Q));
                if ($urandom_range(0, 7) == 0)
                    v = -v;
                if (style == STYLE_EDGY)
                begin
                    case ($urandom_range(0, 4))
                        0:       v = 32'sd0;
                        1:       v = 32'sd1;
                        2:       v = -32'sd1;
                        3:       v = Q_MIN;
                        default: v = Q_MAX;
                    endcase
                end
            end
            SLOT_A1: v = rand_span(3 * ONE_Q / 2);
            SLOT_A2: v = rand_span(ONE_Q - ONE_Q / 8);
            default: v = rand_span(ONE_Q);
        endcase
        return v;
    endfunction

    // All-zero table after reset: every a0 is zero; bad sections and slots are dropped
    task automatic test_reset_state();
        send_item(sample_item(32'sh0123_4567));
        send_item(load_item(4'd3, SLOT_B0, 32'(ONE_Q)));
        send_item(load_item(4'd15, SLOT_A0, 32'(ONE_Q)));
        send_item(load_item(4'd0, 3'd6, 32'(ONE_Q)));
        send_item(load_item(4'd2, 3'd7, 32'(ONE_Q)));
        send_item(sample_item(-32'sd1000));
    endtask

    // b0 = a0 = 1.0 in every section passes samples through unchanged
    task automatic test_identity_passthrough();
        for (int s = 0; s < SECTIONS; s++)
        begin
            send_item(load_item(4'(s), SLOT_B0, 32'(ONE_Q)));
            send_item(load_item(4'(s), SLOT_A0, 32'(ONE_Q)));
        end
        send_item(sample_item(Q_MAX));
        send_item(sample_item(Q_MIN));
        send_item(sample_item(32'sd0));
        send_item(sample_item(-32'sd1));
    endtask

    // Oversized gain and the most negative a0 clip the quotient
    task automatic test_saturation();
        send_item(load_item(4'd0, SLOT_B0, Q_MAX));
        send_item(sample_item(Q_MAX));
        send_item(sample_item(Q_MIN));
        send_item(load_item(4'd0, SLOT_A0, Q_MIN));
        send_item(sample_item(32'sh4000_0000));
    endtask

    // Zero a0 mid-cascade with both signs of numerator
    task automatic test_zero_a0();
        send_item(load_item(4'd1, SLOT_A0, 32'sd0));
        send_item(sample_item(32'sd123456));
        send_item(sample_item(-32'sd123456));
    endtask

    // Random coefficient sets followed by runs of samples, with stray loads mixed in
    task automatic test_random_programs();
        coef_style_t style;
        int          pick;
        logic        full_reload;
        while (counted_items < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                style = STYLE_TAME;
            else if (pick < 17)
                style = STYLE_EDGY;
            else
                style = STYLE_WILD;
            full_reload = ($urandom_range(0, 3) == 0);
            for (int s = 0; s < SECTIONS; s++)
            begin
                for (int k = 0; k < COEFS_PER_SEC; k++)
                begin
                    if (full_reload || $urandom_range(0, 2) == 0)
                        send_item(load_item(4'(s), 3'(k), rand_coef(3'(k), style)));
                end
            end
            repeat ($urandom_range(3, 25))
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_item(load_item(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                                        $signed($urandom)));
                else
                    send_item(sample_item(rand_sample()));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < COEF_DEPTH; i++)
            coef_img[i] = '0;
        for (int i = 0; i < ST_DEPTH; i++)
            state_img[i] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_identity_passthrough();
        test_saturation();
        test_zero_a0();
        test_random_programs();

        // Drain outstanding results, then let the pipeline settle
        @(negedge clk);
        item_valid = 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Filtered %0d samples (%0d flagged overflow), %0d coefficient loads,",
                 filters_sent, overflow_seen, loads_sent);
        $display("%0d out-of-range loads dropped, %0d mismatches in %0d cycles.",
                 ignored_loads, mismatch_count, cycle_count);
        if (mismatch_count == 0 && expected_outputs.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
